// ===== hw/rtl/bdj_pkg.sv =====
// shared types and constants for the retry backoff delay block
// no dependencies; imported by backoff_delay_with_jitter and tb_top
package bdj_pkg;

  localparam int unsigned RegW    = 22;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SprW    = 31;
  localparam int unsigned CntW    = 5;

  localparam logic [CfgIdxW-1:0] REG_MIN_WAIT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_WAIT = 2'd1;

  localparam logic [RegW-1:0] MIN_WAIT_RST = 22'd1;
  localparam logic [RegW-1:0] MAX_WAIT_RST = 22'd300;

  localparam logic [CntW-1:0] MOD_LAST = 5'd31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOUBLE,
    S_MOD,
    S_FINISH
  } state_e;

  // seconds to milliseconds: x * 1000 = x*1024 - x*16 - x*8
  function automatic logic [WordW-1:0] mul_1000(input logic [RegW-1:0] x);
    logic [WordW-1:0] w;
    w = {{(WordW-RegW){1'b0}}, x};
    return (w << 10) - (w << 4) - (w << 3);
  endfunction

  // one fifth of x * 1000: x * 200 = x*128 + x*64 + x*8
  function automatic logic [SprW-1:0] mul_200(input logic [RegW-1:0] x);
    logic [SprW-1:0] w;
    w = {{(SprW-RegW){1'b0}}, x};
    return (w << 7) + (w << 6) + (w << 3);
  endfunction

endpackage

// ===== hw/rtl/backoff_delay_with_jitter.sv =====
// retry delay with exponential backoff and jitter, top level
// depends on bdj_pkg
// each request first doubles the base once per remaining attempt while it stays below the
// ceiling (at most 22 doublings for in-range settings), one step a cycle, then reduces the
// 32-bit random word in a bit-serial modulo; a new request is taken only when the sequencer is idle
// reset (rst_ni low, async): sequencer idle, no result pending, min/max wait back to 1 s / 300 s
module backoff_delay_with_jitter
  import bdj_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [RegW-1:0]     cfg_data_i,

  // input requests
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [63:0]         s_axis_tdata_i,   // [31:0] attempt, [63:32] random_word

  // results
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [31:0]         m_axis_tdata_o    // [31:0] wait_ms
);

  // configuration registers
  logic [RegW-1:0] min_wait_q, max_wait_q;

  // sequencer
  state_e state_q, state_d;

  // datapath
  logic [WordW:0]   base_q, base_d;     // one spare bit for the last doubling
  logic [SprW-1:0]  spr_q, spr_d;       // always base / 5, base is a multiple of 1000
  logic [WordW-1:0] ceil_q, ceil_d;
  logic [SprW-1:0]  cspr_q, cspr_d;     // ceiling / 5
  logic [WordW-1:0] rem_q, rem_d;       // doublings still allowed by the attempt count
  logic [WordW-1:0] rnd_q, rnd_d;       // random word, shifted out msb first
  logic [SprW-1:0]  rmd_q, rmd_d;       // running remainder
  logic [CntW-1:0]  cnt_q, cnt_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_data_q, out_data_d;

  logic             in_fire;
  logic             out_fire;
  logic             can_double;
  logic [WordW-1:0] modulus;
  logic [WordW-1:0] trial;
  logic [WordW-1:0] trial_sub;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = out_valid_q && m_axis_tready_i;

  // keep doubling while attempts remain, base is below the ceiling and nonzero
  assign can_double = (rem_q != '0) && (base_q < {1'b0, ceil_q}) && (base_q != '0);

  // modulus 2*spread + 1, spread stays below 2^30 after the clamp
  assign modulus   = {spr_q, 1'b1};
  assign trial     = {rmd_q, rnd_q[WordW-1]};
  assign trial_sub = trial - modulus;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_wait_q <= MIN_WAIT_RST;
      max_wait_q <= MAX_WAIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MIN_WAIT: min_wait_q <= cfg_data_i;
        REG_MAX_WAIT: max_wait_q <= cfg_data_i;
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    spr_q      <= spr_d;
    ceil_q     <= ceil_d;
    cspr_q     <= cspr_d;
    rem_q      <= rem_d;
    rnd_q      <= rnd_d;
    rmd_q      <= rmd_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    spr_d       = spr_q;
    ceil_d      = ceil_q;
    cspr_d      = cspr_q;
    rem_d       = rem_q;
    rnd_d       = rnd_q;
    rmd_d       = rmd_q;
    cnt_d       = cnt_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_fire;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // start from min * 1000 ms and snapshot the ceiling
          base_d  = {1'b0, mul_1000(min_wait_q)};
          spr_d   = mul_200(min_wait_q);
          ceil_d  = mul_1000(max_wait_q);
          cspr_d  = mul_200(max_wait_q);
          rem_d   = s_axis_tdata_i[31:0];
          rnd_d   = s_axis_tdata_i[63:32];
          state_d = S_DOUBLE;
        end
      end
      S_DOUBLE: begin
        if (can_double) begin
          base_d = base_q << 1;
          spr_d  = spr_q << 1;
          rem_d  = rem_q - 1'b1;
        end else begin
          // clamp to the ceiling, spread follows
          if (base_q > {1'b0, ceil_q}) begin
            base_d = {1'b0, ceil_q};
            spr_d  = cspr_q;
          end
          rmd_d   = '0;
          cnt_d   = '0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        // restoring remainder, one bit of the random word a cycle
        if (trial >= modulus) begin
          rmd_d = trial_sub[SprW-1:0];
        end else begin
          rmd_d = trial[SprW-1:0];
        end
        rnd_d = rnd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MOD_LAST) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the result register to be free
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_d  = base_q[WordW-1:0] - {1'b0, spr_q} + {1'b0, rmd_q};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // spread tracks base / 5 exactly through doubling and clamping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> ({2'b0, spr_q, 2'b0} + {3'b0, spr_q}) == {1'b0, base_q})
    else $error("spread does not match base / 5");

  // base never exceeds the ceiling once the modulo runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> base_q <= {1'b0, ceil_q})
    else $error("base above ceiling after clamp");

  // the running remainder stays below the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> {1'b0, rmd_q} < modulus)
    else $error("remainder out of range");

  // a request that is taken starts the doubling loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_DOUBLE))
    else $error("accepted request did not start");
`endif

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for backoff_delay_with_jitter: streams attempt/random requests,
// predicts every retry delay in the bench and compares it with the block's results
// depends on bdj_pkg and the backoff_delay_with_jitter rtl
module tb_top
  import bdj_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // scaling constants of the backoff computation
  localparam longint unsigned MsPerSecond = 1000;
  localparam longint unsigned JitterPct   = 20;
  localparam longint unsigned PctScale    = 100;

  // register indexes with no register behind them, writes must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [RegW-1:0] REG_ALL_ONES = '1;
  localparam logic [RegW-1:0] RANGE_TOP    = 22'd3000000;

  // slack after the drain: covers the longest request, with up to 22 doublings, padded
  localparam int unsigned DrainSlack = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = REG_MIN_WAIT;
  logic [RegW-1:0]    cfg_data_i = '0;

  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;   // [31:0] attempt, [63:32] random_word

  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // [31:0] wait_ms

  // bench copy of the two wait registers
  logic [RegW-1:0] cfg_min_s = MIN_WAIT_RST;
  logic [RegW-1:0] cfg_max_s = MAX_WAIT_RST;

  // predicted delays, oldest first
  logic [31:0] pending_wait_ms[$];
  int unsigned mismatch_count = 0;

  // idling odds in percent per cycle, and a long receiver hold-off counter
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;

  backoff_delay_with_jitter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // retry delay: double the base per attempt below the ceiling, clamp, then add jitter
  // computed at 64 bits and cut to 32, so settings beyond range wrap like the block
  function automatic logic [31:0] calc_wait_ms(input logic [31:0] attempt,
                                               input logic [31:0] rnd);
    longint unsigned ceil_ms, base_ms, spread_ms, delay_ms, n;
    ceil_ms = longint'(cfg_max_s) * MsPerSecond;
    base_ms = longint'(cfg_min_s) * MsPerSecond;
    n = 0;
    // a zero base never grows, so large attempt counts stop early
    while (n < longint'(attempt) && base_ms < ceil_ms && base_ms != 0) begin
      base_ms = base_ms * 2;
      n++;
    end
    if (base_ms > ceil_ms) begin
      base_ms = ceil_ms;
    end
    spread_ms = base_ms * JitterPct / PctScale;
    delay_ms = base_ms - spread_ms + longint'(rnd) % (2 * spread_ms + 1);
    return delay_ms[31:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch: %s, wait_ms got %0d expected %0d", $realtime, what, got, want);
  endtask

  // one register write; valid stays up so back-to-back writes need no toggle
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_MIN_WAIT: begin
        cfg_min_s = data;
      end
      REG_MAX_WAIT: begin
        cfg_max_s = data;
      end
      default: begin
      end
    endcase
  endtask

  // stop offering requests and wait until every predicted result was taken
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_wait_ms.size() != 0) @(posedge clk_i);
  endtask

  // program both wait registers while the block is idle
  task automatic apply_config(input logic [RegW-1:0] min_s, input logic [RegW-1:0] max_s);
    wait_drained();
    cfg_write(REG_MIN_WAIT, min_s);
    cfg_write(REG_MAX_WAIT, max_s);
    cfg_valid_i <= 1'b0;
  endtask

  // offer one request, optionally after random idle cycles; valid is left high
  // afterwards so a following request goes out without a low blip
  task automatic send_request(input logic [31:0] attempt, input logic [31:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {rnd, attempt};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_wait_ms.push_back(calc_wait_ms(attempt, rnd));
  endtask

  // mostly short attempt counts where doubling matters, sometimes any 32-bit value
  task automatic send_random_requests(input int unsigned count);
    logic [31:0] attempt;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        attempt = $urandom;
      end else begin
        attempt = $urandom_range(0, 30);
      end
      send_request(attempt, $urandom);
    end
  endtask

  // random settings: typical spans, zero minimum, inverted bounds, full 22-bit values
  task automatic apply_random_config();
    logic [RegW-1:0] min_s, max_s;
    case ($urandom_range(7))
      0: begin
        min_s = '0;
        max_s = RegW'($urandom_range(0, RANGE_TOP));
      end
      1: begin
        min_s = RegW'($urandom);
        max_s = RegW'($urandom);
      end
      2: begin
        max_s = RegW'($urandom_range(0, 5000));
        min_s = max_s + RegW'($urandom_range(1, 5000));
      end
      3: begin
        min_s = RegW'($urandom_range(0, RANGE_TOP));
        max_s = RegW'($urandom_range(0, RANGE_TOP));
      end
      default: begin
        min_s = RegW'($urandom_range(1, 600));
        max_s = RegW'($urandom_range(1, RANGE_TOP));
      end
    endcase
    wait_drained();
    // now and then poke a spare index first, it must not disturb anything
    if ($urandom_range(3) == 0) begin
      cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, RegW'($urandom));
    end
    cfg_write(REG_MIN_WAIT, min_s);
    cfg_write(REG_MAX_WAIT, max_s);
    cfg_valid_i <= 1'b0;
  endtask

  // reset settings 1 s / 300 s: no doubling, plain doubling, clamp, word extremes
  task automatic test_reset_defaults();
    send_request(32'd0, 32'd0);
    send_request(32'd0, 32'hFFFF_FFFF);
    send_request(32'd1, 32'd12345);
    send_request(32'd8, 32'hFFFF_FFFF);
    send_request(32'd9, 32'd0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h8000_0000, 32'hAAAA_AAAA);
  endtask

  // zero minimum gives zero delay whatever the attempt or random word
  task automatic test_zero_minimum();
    apply_config('0, MAX_WAIT_RST);
    send_request(32'd0, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'h5555_5555);
    apply_config('0, '0);
    send_request(32'd5, 32'hFFFF_FFFF);
  endtask

  // minimum above maximum clamps the base down to the ceiling
  task automatic test_inverted_bounds();
    apply_config(22'd500, 22'd100);
    send_request(32'd0, 32'hFFFF_FFFF);
    send_request(32'd3, 32'h1234_5678);
  endtask

  // range limits: largest values, longest doubling run, settings past the range that wrap
  task automatic test_setting_extremes();
    apply_config(RANGE_TOP, RANGE_TOP);
    send_request(32'd0, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd0);
    apply_config(22'd1, RANGE_TOP);
    send_request(32'd21, $urandom);
    send_request(32'd22, $urandom);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    apply_config(REG_ALL_ONES, REG_ALL_ONES);
    // largest jitter on the largest base overflows 32 bits
    send_request(32'd0, 32'd1677721200);
    send_request(32'd0, 32'hFFFF_FFFF);
    apply_config(22'd1, REG_ALL_ONES);
    send_request(32'hFFFF_FFFF, 32'h0F0F_F0F0);
  endtask

  // writes to indexes past the register list are dropped
  task automatic test_spare_indexes();
    apply_config(22'd7, 22'd900);
    cfg_write(REG_SPARE_2, REG_ALL_ONES);
    cfg_write(REG_SPARE_3, '0);
    cfg_valid_i <= 1'b0;
    send_request(32'd4, $urandom);
  endtask

  // bulk traffic in blocks of 50 with fresh settings before each block
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned done = 0; done < count; done += 50) begin
      apply_random_config();
      send_random_requests(50);
    end
  endtask

  // receiver stalls for a long stretch so the block backs up into its input
  task automatic test_receiver_holdoff();
    apply_config(22'd2, 22'd5000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 400;
    send_random_requests(12);
  endtask

  // sender goes quiet until everything is back, then resumes
  task automatic test_sender_pause();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    send_random_requests(8);
    wait_drained();
    send_random_requests(8);
  endtask

  // result side: random or held-off ready, decided at each rising edge
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_wait_ms.size() == 0) begin
        report_mismatch("result with no request outstanding", m_axis_tdata_o, '0);
      end else begin
        want = pending_wait_ms.pop_front();
        if (m_axis_tdata_o !== want) begin
          report_mismatch("wait_ms differs", m_axis_tdata_o, want);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with a lazy receiver
    send_idle_pct = 6;
    recv_idle_pct = 60;
    test_reset_defaults();
    test_zero_minimum();
    test_inverted_bounds();
    test_setting_extremes();
    test_spare_indexes();

    // random part: lazy receiver, then lazy sender, then full speed
    test_random_traffic(6, 60, 400);
    test_receiver_holdoff();
    test_random_traffic(60, 6, 400);
    test_sender_pause();
    test_random_traffic(0, 0, 400);

    wait_drained();
    repeat (DrainSlack) @(posedge clk_i);
    if (pending_wait_ms.size() != 0) begin
      report_mismatch("result never arrived", '0, pending_wait_ms[0]);
    end
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
